[rtl/core/vcfc_pkg.sv]
// ---------------------------------------------------------------------------
// vcfc_pkg: shared types and constants for the vertex channel converter
// Format codes, opcodes, lane control and the reciprocal tables for
// 8-bit normalised unpack.
// ---------------------------------------------------------------------------
package vcfc_pkg;

  localparam int unsigned NUM_LANES = 4;

  // channel format codes
  localparam logic [2:0] FMT_UNORM8    = 3'd0;
  localparam logic [2:0] FMT_SNORM8    = 3'd1;
  localparam logic [2:0] FMT_RG_HALF   = 3'd2;
  localparam logic [2:0] FMT_RGBA_HALF = 3'd3;
  localparam logic [2:0] FMT_R_FLOAT   = 3'd4;
  localparam logic [2:0] FMT_RG_FLOAT  = 3'd5;
  localparam logic [2:0] FMT_RGB_FLOAT = 3'd6;
  localparam logic [2:0] FMT_RGBA_FLOAT = 3'd7;
  localparam logic [2:0] FMT_RESET     = FMT_RGBA_FLOAT;

  // opcodes
  localparam logic OP_PACK   = 1'b0;
  localparam logic OP_UNPACK = 1'b1;

  typedef struct packed {
    logic [2:0] fmt;
    logic       op;
  } lane_ctrl_t;

  typedef logic [31:0] recip_tbl_t [256];

  // Float32 of b/255 (unorm) or max(s/127,-1) (snorm), correctly rounded.
  // Evaluated at elaboration only.
  function automatic recip_tbl_t build_recip_tbl(input logic snorm);
    recip_tbl_t tbl;
    int         s;
    longint     mag;
    longint     num;
    longint     q;
    longint     r;
    longint     dv;
    int         k;
    int         kf;
    logic       found;
    logic       sgn;
    for (int b = 0; b < 256; b++) begin
      s   = (snorm && b >= 128) ? b - 256 : b;
      sgn = (s < 0);
      mag = sgn ? -s : s;
      dv  = snorm ? 127 : 255;
      if (snorm && s == -128) begin
        tbl[b] = 32'hBF80_0000;
      end else if (mag == 0) begin
        tbl[b] = 32'h0;
      end else begin
        found = 1'b0;
        kf    = 0;
        q     = 0;
        r     = 0;
        for (k = 0; k < 48; k++) begin
          num = mag << k;
          if (!found) begin
            if (snorm) q = num / 127;
            else       q = num / 255;
            if (q >= (64'd1 << 23)) begin
              found = 1'b1;
              kf    = k;
              r     = num - q * dv;
            end
          end
        end
        if (2 * r > dv) q = q + 1;
        if (q == (64'd1 << 24)) begin
          q  = 64'd1 << 23;
          kf = kf - 1;
        end
        tbl[b] = {sgn, 8'(150 - kf), 23'(q)};
      end
    end
    return tbl;
  endfunction

endpackage

[rtl/core/vertex_channel_format_convert_core.sv]
// ---------------------------------------------------------------------------
// vertex_channel_format_convert_core: vertex channel pack/unpack
// Four component lanes feed a merge stage that builds the packed bytes
// or the unpacked floats, registered onto the result ports.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive opcode and payload with start high; the item is
//   taken on any edge where start is high and busy is low. busy is never
//   raised, so one item may be issued every cycle.
//   Results: done pulses for one cycle in the cycle after the item is
//   taken, with all result ports valid in that cycle. Throughput is 1 item
//   per cycle, set by the single register stage behind the four lanes
//   and merge logic.
//   The receiver cannot stall; each result must be taken when done is high.
//   Config channel: cfg_data is written into channel_format on an edge with
//   cfg_valid high (cfg_ready is always high). Write it only while idle.
//   Reset (rst, synchronous): clears done and sets channel_format to the
//   rgba float format. No clearing pass is needed.
//   byte_count gives bytes per vertex for the current format on both
//   opcodes; unused bytes and absent components read as zero.
// ---------------------------------------------------------------------------
module vertex_channel_format_convert_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [31:0] value_x,
  input  logic [31:0] value_y,
  input  logic [31:0] value_z,
  input  logic [31:0] value_w,
  input  logic [63:0] packed_low,
  input  logic [63:0] packed_high,
  output logic        done,
  output logic [31:0] result_x,
  output logic [31:0] result_y,
  output logic [31:0] result_z,
  output logic [31:0] result_w,
  output logic [63:0] encoded_low,
  output logic [63:0] encoded_high,
  output logic [4:0]  byte_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  import vcfc_pkg::*;

  logic [2:0]   channel_format;
  logic         op_q;
  lane_ctrl_t   ctrl;
  logic [127:0] src_all;
  logic [31:0]  vals [NUM_LANES];
  logic [7:0]   un8 [NUM_LANES];
  logic [7:0]   sn8 [NUM_LANES];
  logic [15:0]  hf16 [NUM_LANES];
  logic [31:0]  unp [NUM_LANES];
  logic [127:0] enc_next;
  logic [31:0]  res_next [NUM_LANES];
  logic [2:0]   present;
  logic [4:0]   count_next;
  logic         take;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;
  assign ctrl.fmt  = channel_format;
  assign ctrl.op   = opcode;
  assign src_all   = {packed_high, packed_low};
  assign vals[0]   = value_x;
  assign vals[1]   = value_y;
  assign vals[2]   = value_z;
  assign vals[3]   = value_w;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_format <= FMT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      channel_format <= cfg_data;
    end
  end

  // component lanes
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    vcfc_lane u_lane (
      .ctrl     (ctrl),
      .value    (vals[k]),
      .src_word (src_all[32*k +: 32]),
      .src_half (src_all[16*k +: 16]),
      .src_byte (src_all[8*k +: 8]),
      .unorm8   (un8[k]),
      .snorm8   (sn8[k]),
      .half16   (hf16[k]),
      .unpacked (unp[k])
    );
  end

  // merge: byte layout, present components and byte count
  always_comb begin
    unique case (channel_format)
      FMT_UNORM8: begin
        enc_next   = {96'd0, un8[3], un8[2], un8[1], un8[0]};
        present    = 3'd4;
        count_next = 5'd4;
      end
      FMT_SNORM8: begin
        enc_next   = {96'd0, sn8[3], sn8[2], sn8[1], sn8[0]};
        present    = 3'd4;
        count_next = 5'd4;
      end
      FMT_RG_HALF: begin
        enc_next   = {96'd0, hf16[1], hf16[0]};
        present    = 3'd2;
        count_next = 5'd4;
      end
      FMT_RGBA_HALF: begin
        enc_next   = {64'd0, hf16[3], hf16[2], hf16[1], hf16[0]};
        present    = 3'd4;
        count_next = 5'd8;
      end
      FMT_R_FLOAT: begin
        enc_next   = {96'd0, vals[0]};
        present    = 3'd1;
        count_next = 5'd4;
      end
      FMT_RG_FLOAT: begin
        enc_next   = {64'd0, vals[1], vals[0]};
        present    = 3'd2;
        count_next = 5'd8;
      end
      FMT_RGB_FLOAT: begin
        enc_next   = {32'd0, vals[2], vals[1], vals[0]};
        present    = 3'd3;
        count_next = 5'd12;
      end
      default: begin
        enc_next   = {vals[3], vals[2], vals[1], vals[0]};
        present    = 3'd4;
        count_next = 5'd16;
      end
    endcase
    for (int k = 0; k < NUM_LANES; k++) begin
      res_next[k] = (3'(k) < present) ? unp[k] : 32'd0;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= take;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (take) begin
      op_q         <= opcode;
      byte_count   <= count_next;
      encoded_low  <= (opcode == OP_PACK) ? enc_next[63:0] : 64'd0;
      encoded_high <= (opcode == OP_PACK) ? enc_next[127:64] : 64'd0;
      result_x     <= (opcode == OP_UNPACK) ? res_next[0] : 32'd0;
      result_y     <= (opcode == OP_UNPACK) ? res_next[1] : 32'd0;
      result_z     <= (opcode == OP_UNPACK) ? res_next[2] : 32'd0;
      result_w     <= (opcode == OP_UNPACK) ? res_next[3] : 32'd0;
    end
  end

`ifndef SYNTH
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> done) else $error("item taken but no done pulse");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !take |=> !done) else $error("done without an item");
  a_pack_res_zero: assert property (@(posedge clk) disable iff (rst)
    (done && op_q == OP_PACK) |-> (result_x == 32'd0 && result_w == 32'd0))
    else $error("pack result carries float data");
  a_unpack_enc_zero: assert property (@(posedge clk) disable iff (rst)
    (done && op_q == OP_UNPACK) |-> (encoded_low == 64'd0 && encoded_high == 64'd0))
    else $error("unpack result carries encoded bytes");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (byte_count != 5'd0 && byte_count <= 5'd16))
    else $error("byte count out of range");
`endif

endmodule

[rtl/core/vcfc_lane.sv]
// ---------------------------------------------------------------------------
// vcfc_lane: one component's converter
// Packs one float32 into unorm8, snorm8 and half, and unpacks one
// component from its source bytes in the selected format.
// ---------------------------------------------------------------------------
module vcfc_lane (
  input  vcfc_pkg::lane_ctrl_t ctrl,
  input  logic [31:0]          value,
  input  logic [31:0]          src_word,
  input  logic [15:0]          src_half,
  input  logic [7:0]           src_byte,
  output logic [7:0]           unorm8,
  output logic [7:0]           snorm8,
  output logic [15:0]          half16,
  output logic [31:0]          unpacked
);
  import vcfc_pkg::*;

  localparam recip_tbl_t UNORM_TBL = build_recip_tbl(1'b0);
  localparam recip_tbl_t SNORM_TBL = build_recip_tbl(1'b1);

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [31:0] prod;
  logic [23:0] keep;
  logic        rup;
  logic [33:0] prnd;
  logic [7:0]  sh;
  logic [34:0] biased;
  logic [34:0] rint;
  logic        is_nan;
  logic        sat;
  logic [7:0]  mag_u;
  logic [7:0]  mag_s;
  logic [15:0] hin;
  logic [9:0]  hsig;
  logic [4:0]  hexp;
  logic [3:0]  lead;
  logic [9:0]  hnorm;
  logic [31:0] hfloat;

  assign sgn  = value[31];
  assign ex   = value[30:23];
  assign frac = value[22:0];
  assign mant = {ex != 8'd0, frac};
  assign is_nan = (ex == 8'hFF) && (frac != 23'd0);

  // x*255 rounded to float precision, then rounded half away from zero
  always_comb begin
    prod = 32'(mant) * 32'd255;
    if (prod[31]) begin
      keep = prod[31:8];
      rup  = prod[7] & ((|prod[6:0]) | prod[8]);
      prnd = 34'({1'b0, keep} + 25'(rup)) << 8;
    end else begin
      keep = prod[30:7];
      rup  = prod[6] & ((|prod[5:0]) | prod[7]);
      prnd = 34'({1'b0, keep} + 25'(rup)) << 7;
    end
    sh     = 8'd150 - ex;
    biased = {1'b0, prnd} + (35'd1 << (sh - 8'd1));
    rint   = (sh > 8'd34) ? 35'd0 : (biased >> sh);
    sat    = (ex >= 8'd136);
  end

  // same rounding on x*127: the product exponent differs, so redo it
  logic [31:0] prod7;
  logic [23:0] keep7;
  logic        rup7;
  logic [33:0] prnd7;
  logic [34:0] biased7;
  logic [34:0] rint7;

  always_comb begin
    prod7 = 32'(mant) * 32'd127;
    if (prod7[30]) begin
      keep7 = prod7[30:7];
      rup7  = prod7[6] & ((|prod7[5:0]) | prod7[7]);
      prnd7 = 34'({1'b0, keep7} + 25'(rup7)) << 7;
    end else begin
      keep7 = prod7[29:6];
      rup7  = prod7[5] & ((|prod7[4:0]) | prod7[6]);
      prnd7 = 34'({1'b0, keep7} + 25'(rup7)) << 6;
    end
    biased7 = {1'b0, prnd7} + (35'd1 << (sh - 8'd1));
    rint7   = (sh > 8'd34) ? 35'd0 : (biased7 >> sh);
  end

  // clamp and encode the 8-bit forms
  always_comb begin
    if (ex == 8'd0)          mag_u = 8'd0;
    else if (sat)            mag_u = 8'd255;
    else if (rint > 35'd255) mag_u = 8'd255;
    else                     mag_u = rint[7:0];
    if (ex == 8'd0)           mag_s = 8'd0;
    else if (sat)             mag_s = 8'd127;
    else if (rint7 > 35'd127) mag_s = 8'd127;
    else                      mag_s = rint7[7:0];
    if (is_nan || sgn) unorm8 = 8'd0;
    else               unorm8 = mag_u;
    if (is_nan)   snorm8 = 8'd0;
    else if (sgn) snorm8 = 8'd0 - mag_s;
    else          snorm8 = mag_s;
  end

  // float to half, mantissa truncated, small values flush to +0
  always_comb begin
    if (ex >= 8'd143) begin
      half16 = {sgn, 5'h1F, is_nan ? 10'h3FF : 10'h000};
    end else if (ex <= 8'd112) begin
      half16 = 16'h0;
    end else begin
      half16 = {sgn, 5'(ex - 8'd112), frac[22:13]};
    end
  end

  // half to float, subnormals normalised by leading-one position
  assign hin  = src_half;
  assign hsig = hin[9:0];
  assign hexp = hin[14:10];

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hsig[i]) lead = 4'(i);
    end
    hnorm = 10'(hsig << (4'd10 - lead));
    if (hexp == 5'd0) begin
      if (hsig == 10'd0) hfloat = {hin[15], 31'd0};
      else hfloat = {hin[15], 8'(8'd103 + 8'(lead)), hnorm, 13'd0};
    end else if (hexp == 5'h1F) begin
      hfloat = {hin[15], 8'hFF, hsig, 13'd0};
    end else begin
      hfloat = {hin[15], 8'(8'(hexp) + 8'd112), hsig, 13'd0};
    end
  end

  // unpack source selection, zero on pack
  always_comb begin
    if (ctrl.op == OP_PACK) begin
      unpacked = 32'd0;
    end else begin
      unique case (ctrl.fmt)
        FMT_UNORM8:    unpacked = UNORM_TBL[src_byte];
        FMT_SNORM8:    unpacked = SNORM_TBL[src_byte];
        FMT_RG_HALF,
        FMT_RGBA_HALF: unpacked = hfloat;
        default:       unpacked = src_word;
      endcase
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: vertex channel format converter
// Walks a short table of hand-picked vertices across every channel format,
// then streams random pack and unpack items through each format in turn.
// Every result is checked field by field against a bit-exact predictor or a stored expected result.
// ---------------------------------------------------------------------------
module testbench;
  import vcfc_pkg::*;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] rw;
    logic [63:0] elo;
    logic [63:0] ehi;
    logic [4:0]  cnt;
  } vertex_res_t;

  typedef struct {
    logic [2:0]  fmt;
    logic        op;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] vw;
    logic [63:0] plo;
    logic [63:0] phi;
    logic        fixed;
    vertex_res_t res;
  } vertex_row_t;

  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode = OP_PACK;
  logic [31:0] value_x = '0;
  logic [31:0] value_y = '0;
  logic [31:0] value_z = '0;
  logic [31:0] value_w = '0;
  logic [63:0] packed_low = '0;
  logic [63:0] packed_high = '0;
  logic        done;
  logic [31:0] result_x;
  logic [31:0] result_y;
  logic [31:0] result_z;
  logic [31:0] result_w;
  logic [63:0] encoded_low;
  logic [63:0] encoded_high;
  logic [4:0]  byte_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;

  logic [2:0]  cur_fmt = FMT_RESET;
  vertex_res_t vertex_q[$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_cfg = 0;
  int          idle_cycles = 0;

  always #2 clk = ~clk;

  vertex_channel_format_convert_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .value_x(value_x), .value_y(value_y), .value_z(value_z), .value_w(value_w),
    .packed_low(packed_low), .packed_high(packed_high), .done(done),
    .result_x(result_x), .result_y(result_y), .result_z(result_z),
    .result_w(result_w), .encoded_low(encoded_low), .encoded_high(encoded_high),
    .byte_count(byte_count), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // float32 -> normalised byte: product rounded to float32, clamped, half away
  function automatic logic [7:0] norm_byte(logic [31:0] f, logic sn);
    longint q;
    longint rem;
    longint halfv;
    longint ip;
    longint hi;
    longint fb;
    int     e;
    int     l;
    int     sh;
    int     ne;
    hi = sn ? 127 : 255;
    if (f[30:23] == 8'hFF) begin
      if (f[22:0] != 0) return 8'h00;
      if (f[31]) return sn ? 8'(-hi) : 8'h00;
      return 8'(hi);
    end
    q = (f[30:23] != 0) ? longint'({1'b1, f[22:0]}) : longint'(f[22:0]);
    q = q * hi;
    if (q == 0) return 8'h00;
    e = ((f[30:23] != 0) ? int'(f[30:23]) : 1) - 150;
    l = 0;
    while ((q >> l) != 0) l++;
    sh = (l > 24) ? l - 24 : 0;
    if (sh > 0) begin
      rem   = q & ((64'sd1 << sh) - 1);
      q     = q >> sh;
      halfv = 64'sd1 << (sh - 1);
      if (rem > halfv || (rem == halfv && q[0])) q++;
    end
    ne = e + sh;
    if (ne > 16) ip = hi;
    else if (ne >= 0) ip = q << ne;
    else if (ne < -40) ip = 0;
    else begin
      ip = q >> (-ne);
      fb = q & ((64'sd1 << (-ne)) - 1);
      if (fb >= (64'sd1 << (-ne - 1))) ip++;
    end
    if (ip > hi) ip = hi;
    if (f[31]) return sn ? 8'(-ip) : 8'h00;
    return 8'(ip);
  endfunction

  // magnitude / divisor as a correctly rounded float32
  function automatic logic [31:0] ratio_float(logic sgn, int mag, int dv);
    longint q;
    longint r;
    int     k;
    int     kf;
    logic   found;
    if (mag == 0) return 32'h0;
    found = 1'b0;
    kf = 0;
    q = 0;
    r = 0;
    for (k = 0; k < 40; k++) begin
      if (!found && ((longint'(mag) << k) / dv) >= (64'sd1 << 23)) begin
        found = 1'b1;
        kf = k;
        q = (longint'(mag) << k) / dv;
        r = (longint'(mag) << k) - q * dv;
      end
    end
    if (2 * r > dv) q++;
    if (q == (64'sd1 << 24)) begin
      q = 64'sd1 << 23;
      kf--;
    end
    return {sgn, 8'(150 - kf), q[22:0]};
  endfunction

  function automatic logic [15:0] to_half(logic [31:0] x);
    logic [31:0] expo;
    logic [22:0] mant;
    expo = x & 32'h7F80_0000;
    mant = x[22:0];
    if (expo >= 32'h4780_0000) begin
      if (expo == 32'h7F80_0000 && mant != 0) return {x[31], 15'h7FFF};
      return {x[31], 15'h7C00};
    end
    if (expo <= 32'h3800_0000) return 16'h0;
    return {x[31], 15'((expo - 32'h3800_0000) >> 13) | 15'(mant >> 13)};
  endfunction

  function automatic logic [31:0] from_half(logic [15:0] h);
    logic [10:0] sig;
    int          steps;
    sig = {1'b0, h[9:0]};
    steps = 0;
    if (h[14:10] == 0) begin
      if (sig == 0) return {h[15], 31'h0};
      sig = sig << 1;
      while (!sig[10]) begin
        sig = sig << 1;
        steps++;
      end
      return {h[15], 8'(112 - steps), sig[9:0], 13'h0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'h0};
    return {h[15], 8'(h[14:10] + 112), h[9:0], 13'h0};
  endfunction

  // expected conversion of one vertex under format fmt
  function automatic vertex_res_t convert_vertex(logic [2:0] fmt, logic op,
      logic [127:0] vals, logic [63:0] plo, logic [63:0] phi);
    vertex_res_t  r;
    logic [127:0] enc;
    logic [127:0] pk;
    logic [31:0]  comp[4];
    logic [7:0]   b;
    int           k;
    int           nc;
    r = '0;
    enc = '0;
    pk = {phi, plo};
    for (k = 0; k < 4; k++) comp[k] = 32'h0;
    case (fmt)
      FMT_UNORM8, FMT_SNORM8, FMT_RG_HALF: r.cnt = 5'd4;
      FMT_RGBA_HALF: r.cnt = 5'd8;
      default: r.cnt = 5'((fmt - 3) * 4);
    endcase
    nc = (fmt >= FMT_R_FLOAT) ? int'(fmt) - 3 : (fmt == FMT_RG_HALF) ? 2 : 4;
    for (k = 0; k < nc; k++) begin
      if (op == OP_UNPACK) begin
        case (fmt)
          FMT_UNORM8: comp[k] = ratio_float(1'b0, int'(pk[8*k +: 8]), 255);
          FMT_SNORM8: begin
            b = pk[8*k +: 8];
            if (b == 8'h80) comp[k] = 32'hBF80_0000;
            else comp[k] = ratio_float(b[7], b[7] ? 256 - int'(b) : int'(b), 127);
          end
          FMT_RG_HALF, FMT_RGBA_HALF: comp[k] = from_half(pk[16*k +: 16]);
          default: comp[k] = pk[32*k +: 32];
        endcase
      end else begin
        case (fmt)
          FMT_UNORM8: enc[8*k +: 8] = norm_byte(vals[32*k +: 32], 1'b0);
          FMT_SNORM8: enc[8*k +: 8] = norm_byte(vals[32*k +: 32], 1'b1);
          FMT_RG_HALF, FMT_RGBA_HALF: enc[16*k +: 16] = to_half(vals[32*k +: 32]);
          default: enc[32*k +: 32] = vals[32*k +: 32];
        endcase
      end
    end
    r.rx = comp[0];
    r.ry = comp[1];
    r.rz = comp[2];
    r.rw = comp[3];
    r.elo = enc[63:0];
    r.ehi = enc[127:64];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, n_results);
  endtask

  // append one expected result to the scoreboard
  task automatic queue_expected(vertex_res_t r);
    vertex_q = {vertex_q, r};
  endtask

  // result check and watchdog
  always @(posedge clk) begin
    vertex_res_t want;
    if (!rst) begin
      if (done) begin
        n_results++;
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(done), 64'd0);
        end else begin
          want = vertex_q.pop_front();
          if (result_x !== want.rx) report_mismatch("result_x", result_x, want.rx);
          if (result_y !== want.ry) report_mismatch("result_y", result_y, want.ry);
          if (result_z !== want.rz) report_mismatch("result_z", result_z, want.rz);
          if (result_w !== want.rw) report_mismatch("result_w", result_w, want.rw);
          if (encoded_low !== want.elo) report_mismatch("encoded_low", encoded_low, want.elo);
          if (encoded_high !== want.ehi)
            report_mismatch("encoded_high", encoded_high, want.ehi);
          if (byte_count !== want.cnt) report_mismatch("byte_count", byte_count, want.cnt);
        end
      end
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // write the format register once all results are in
  task automatic write_format(logic [2:0] fmt);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = fmt;
    do @(posedge clk); while (!cfg_ready);
    cur_fmt = fmt;
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drive one item and record its expected result on acceptance
  task automatic send_vertex(logic op, logic [31:0] vx, logic [31:0] vy,
      logic [31:0] vz, logic [31:0] vw, logic [63:0] plo, logic [63:0] phi,
      logic fixed, vertex_res_t given);
    @(negedge clk);
    start = 1'b1;
    opcode = op;
    value_x = vx;
    value_y = vy;
    value_z = vz;
    value_w = vw;
    packed_low = plo;
    packed_high = phi;
    do @(posedge clk); while (busy);
    queue_expected(fixed ? given
                         : convert_vertex(cur_fmt, op, {vw, vz, vy, vx}, plo, phi));
    n_items++;
  endtask

  task automatic idle_gap(logic allow);
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = (!allow || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (g > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] specials[9];
    specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h3F80_0000, 32'hBF80_0000};
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3, 4: return {1'($urandom), 8'($urandom_range(117, 127)), 23'($urandom)};
      5: return {1'($urandom), 8'($urandom_range(118, 126)), 23'($urandom) & 23'h7FFF00};
      6: return specials[$urandom_range(0, 8)];
      7: return {1'($urandom), 8'($urandom_range(108, 116)), 23'($urandom)};
      8: return {1'($urandom), 8'($urandom_range(140, 146)), 23'($urandom)};
      default: return {1'($urandom), {8{1'($urandom)}}, 23'($urandom)};
    endcase
  endfunction

  // directed vertices; fixed rows carry their expected result
  vertex_row_t rows[] = '{
    '{FMT_RGBA_FLOAT, OP_PACK, 32'h3F80_0000, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0,
      64'hFFFF_FFFF_3F80_0000, 64'h8000_0000_0000_0000, 5'd16}},
    '{FMT_RGBA_FLOAT, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1,
      '{32'h89AB_CDEF, 32'h0123_4567, 32'h7654_3210, 32'hFEDC_BA98, 64'h0, 64'h0, 5'd16}},
    '{FMT_UNORM8, OP_PACK, 32'h3F80_0000, 32'h7FC0_0000, 32'h7F80_0000, 32'hBF80_0000,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_00FF_00FF, 64'h0, 5'd4}},
    '{FMT_UNORM8, OP_PACK, 32'h3F00_0000, 32'h3B80_8081, 32'h3F7F_FFFF, 32'h0000_0001,
      64'h0, 64'h0, 1'b0, '0},
    '{FMT_UNORM8, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'hFFFF_FFFF_FF80_01FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{FMT_SNORM8, OP_PACK, 32'h3F80_0000, 32'hBF80_0000, 32'hFF80_0000, 32'h7FC0_0000,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_0081_817F, 64'h0, 5'd4}},
    '{FMT_SNORM8, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'hFFFF_FFFF_007F_8180, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{32'hBF80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h0, 64'h0, 64'h0, 5'd4}},
    '{FMT_SNORM8, OP_PACK, 32'h3F00_0000, 32'hBF00_0000, 32'h3C01_0204, 32'h0000_0001,
      64'h0, 64'h0, 1'b0, '0},
    '{FMT_RG_HALF, OP_PACK, 32'h3F80_0000, 32'hC780_0000, 32'h1234_5678, 32'hFFFF_FFFF,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_FC00_3C00, 64'h0, 5'd4}},
    '{FMT_RG_HALF, OP_PACK, 32'h7FC0_0001, 32'h3880_0000, 32'h0, 32'h0,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_0400_7FFF, 64'h0, 5'd4}},
    '{FMT_RG_HALF, OP_PACK, 32'hB800_0000, 32'h477F_E000, 32'h0, 32'h0,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_7BFF_0000, 64'h0, 5'd4}},
    '{FMT_RG_HALF, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'hFFFF_FFFF_83FF_0001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{FMT_RGBA_HALF, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'hFE01_7C00_8000_0001, 64'h0, 1'b0, '0},
    '{FMT_RGBA_HALF, OP_PACK, 32'h4780_0000, 32'hFF80_0000, 32'h3333_3333, 32'hC000_0000,
      64'h0, 64'h0, 1'b0, '0},
    '{FMT_R_FLOAT, OP_PACK, 32'hDEAD_BEEF, 32'h1, 32'h2, 32'h3,
      64'h0, 64'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 64'h0000_0000_DEAD_BEEF, 64'h0, 5'd4}},
    '{FMT_RG_FLOAT, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'hCAFE_F00D_1234_5678, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{FMT_RGB_FLOAT, OP_UNPACK, 32'h0, 32'h0, 32'h0, 32'h0,
      64'h1111_2222_3333_4444, 64'hFFFF_FFFF_5555_6666, 1'b0, '0},
    '{FMT_RGB_FLOAT, OP_PACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      64'h0, 64'h0, 1'b0, '0}
  };

  // stimulus
  initial begin
    logic [2:0] fmt;
    logic       allow;
    logic       op;
    int         p;
    int         i;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (i = 0; i < rows.size(); i++) begin
      if (rows[i].fmt != cur_fmt) begin
        @(negedge clk);
        start = 1'b0;
        write_format(rows[i].fmt);
      end
      send_vertex(rows[i].op, rows[i].vx, rows[i].vy, rows[i].vz, rows[i].vw,
                  rows[i].plo, rows[i].phi, rows[i].fixed, rows[i].res);
      idle_gap(1'b1);
    end

    // random phases: every format in turn, then random ones
    for (p = 0; p < 12; p++) begin
      fmt = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      allow = (p % 3) != 1;
      @(negedge clk);
      start = 1'b0;
      write_format(fmt);
      for (i = 0; i < 90; i++) begin
        op = 1'($urandom);
        send_vertex(op, rand_float(), rand_float(), rand_float(), rand_float(),
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);
        idle_gap(allow);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("covered %0d vertices, %0d results, %0d format writes over all formats",
             n_items, n_results, n_cfg);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
